@@ hdl/hgpc_pkg.sv @@
// Shared types, constants and register map of the HSV green pixel census.
package hgpc_pkg;

	localparam int unsigned MAX_FRAME_PIXELS = 4194304;
	localparam int unsigned CNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int unsigned PCT_W  = 7;
	localparam int unsigned DIVD_W = CNT_W + PCT_W;
	localparam int unsigned BIT_W  = $clog2(PCT_W);
	localparam int unsigned CH_W   = 8;

	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_FRAME_PIXELS);
	localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
	localparam logic [PCT_W-1:0] GRADE_CUT_LOW  = 7'd20;
	localparam logic [PCT_W-1:0] GRADE_CUT_MID  = 7'd50;
	localparam logic [PCT_W-1:0] GRADE_CUT_HIGH = 7'd80;

	localparam int unsigned PADDR_W   = 5;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_GREEN_HUE_LOW    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_HUE_HIGH   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_SAT_LOW    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_VAL_LOW    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_VAL_HIGH   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_HEALTHY_HUE_LOW  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_HEALTHY_HUE_HIGH = 3'd6;

	localparam logic [CH_W-1:0] RST_GREEN_HUE_LOW    = 8'd45;
	localparam logic [CH_W-1:0] RST_GREEN_HUE_HIGH   = 8'd80;
	localparam logic [CH_W-1:0] RST_GREEN_SAT_LOW    = 8'd30;
	localparam logic [CH_W-1:0] RST_GREEN_VAL_LOW    = 8'd30;
	localparam logic [CH_W-1:0] RST_GREEN_VAL_HIGH   = 8'd200;
	localparam logic [CH_W-1:0] RST_HEALTHY_HUE_LOW  = 8'd55;
	localparam logic [CH_W-1:0] RST_HEALTHY_HUE_HIGH = 8'd65;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
		logic            last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [CNT_W-1:0] frame_pixels;
		logic [CNT_W-1:0] green_pixels;
		logic [CNT_W-1:0] healthy_pixels;
		logic [PCT_W-1:0] green_percent;
		logic [PCT_W-1:0] healthy_percent;
		logic [1:0]       health_grade;
		logic             no_green;
	} result_t;

	typedef struct packed {
		logic [CH_W-1:0] green_hue_low;
		logic [CH_W-1:0] green_hue_high;
		logic [CH_W-1:0] green_sat_low;
		logic [CH_W-1:0] green_val_low;
		logic [CH_W-1:0] green_val_high;
		logic [CH_W-1:0] healthy_hue_low;
		logic [CH_W-1:0] healthy_hue_high;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] pixels;
		logic [CNT_W-1:0] green;
		logic [CNT_W-1:0] healthy;
	} snap_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV_GREEN,
		BK_DIV_HEALTHY,
		BK_OUT
	} back_state_t;

endpackage

@@ hdl/hgpc_cfg.sv @@
// Threshold register file behind the APB-style configuration port.
module hgpc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hgpc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output hgpc_pkg::cfg_t               cfg
);

	hgpc_pkg::cfg_t cfg_q;
	logic [hgpc_pkg::REG_IDX_W-1:0] idx;
	logic [hgpc_pkg::CH_W-1:0] wdata;
	logic [hgpc_pkg::CH_W-1:0] rdata;
	logic wr_en;

	assign idx   = paddr[hgpc_pkg::PADDR_W-1:2];
	assign wdata = pwdata[hgpc_pkg::CH_W-1:0];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_hue_low    <= hgpc_pkg::RST_GREEN_HUE_LOW;
			cfg_q.green_hue_high   <= hgpc_pkg::RST_GREEN_HUE_HIGH;
			cfg_q.green_sat_low    <= hgpc_pkg::RST_GREEN_SAT_LOW;
			cfg_q.green_val_low    <= hgpc_pkg::RST_GREEN_VAL_LOW;
			cfg_q.green_val_high   <= hgpc_pkg::RST_GREEN_VAL_HIGH;
			cfg_q.healthy_hue_low  <= hgpc_pkg::RST_HEALTHY_HUE_LOW;
			cfg_q.healthy_hue_high <= hgpc_pkg::RST_HEALTHY_HUE_HIGH;
		end else if (wr_en) begin
			case (idx)
				hgpc_pkg::REG_GREEN_HUE_LOW:    cfg_q.green_hue_low    <= wdata;
				hgpc_pkg::REG_GREEN_HUE_HIGH:   cfg_q.green_hue_high   <= wdata;
				hgpc_pkg::REG_GREEN_SAT_LOW:    cfg_q.green_sat_low    <= wdata;
				hgpc_pkg::REG_GREEN_VAL_LOW:    cfg_q.green_val_low    <= wdata;
				hgpc_pkg::REG_GREEN_VAL_HIGH:   cfg_q.green_val_high   <= wdata;
				hgpc_pkg::REG_HEALTHY_HUE_LOW:  cfg_q.healthy_hue_low  <= wdata;
				hgpc_pkg::REG_HEALTHY_HUE_HIGH: cfg_q.healthy_hue_high <= wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			hgpc_pkg::REG_GREEN_HUE_LOW:    rdata = cfg_q.green_hue_low;
			hgpc_pkg::REG_GREEN_HUE_HIGH:   rdata = cfg_q.green_hue_high;
			hgpc_pkg::REG_GREEN_SAT_LOW:    rdata = cfg_q.green_sat_low;
			hgpc_pkg::REG_GREEN_VAL_LOW:    rdata = cfg_q.green_val_low;
			hgpc_pkg::REG_GREEN_VAL_HIGH:   rdata = cfg_q.green_val_high;
			hgpc_pkg::REG_HEALTHY_HUE_LOW:  rdata = cfg_q.healthy_hue_low;
			hgpc_pkg::REG_HEALTHY_HUE_HIGH: rdata = cfg_q.healthy_hue_high;
			default:                        rdata = '0;
		endcase
	end

	assign prdata = {{(32 - hgpc_pkg::CH_W){1'b0}}, rdata};
	assign cfg    = cfg_q;

endmodule

@@ hdl/hgpc_front.sv @@
// Front end: accepts pixels, classifies them and keeps the frame counters.
module hgpc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  hgpc_pkg::cfg_t  cfg,
	input  logic            push,
	input  hgpc_pkg::pixel_t pixel,
	output logic            full,
	input  logic            snap_full,
	output logic            snap_push,
	output hgpc_pkg::snap_t snap
);

	logic [hgpc_pkg::CNT_W-1:0] pix_cnt_q, grn_cnt_q, hlt_cnt_q;
	logic [hgpc_pkg::CNT_W-1:0] pix_nxt, grn_nxt, hlt_nxt;
	logic accept, is_green, is_healthy;

	assign full   = snap_full;
	assign accept = push && !snap_full;

	assign is_green = (pixel.saturation > cfg.green_sat_low) &&
		(pixel.brightness > cfg.green_val_low) &&
		(pixel.brightness < cfg.green_val_high) &&
		(pixel.hue > cfg.green_hue_low) &&
		(pixel.hue < cfg.green_hue_high);
	assign is_healthy = is_green && (pixel.hue > cfg.healthy_hue_low) &&
		(pixel.hue < cfg.healthy_hue_high);

	// Saturate each count at the largest frame size
	always_comb begin
		pix_nxt = (pix_cnt_q < hgpc_pkg::CNT_MAX) ? pix_cnt_q + 1'b1 : pix_cnt_q;
		grn_nxt = grn_cnt_q;
		hlt_nxt = hlt_cnt_q;
		if (is_green && grn_cnt_q < hgpc_pkg::CNT_MAX) begin
			grn_nxt = grn_cnt_q + 1'b1;
		end
		if (is_healthy && hlt_cnt_q < hgpc_pkg::CNT_MAX) begin
			hlt_nxt = hlt_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
			grn_cnt_q <= '0;
			hlt_cnt_q <= '0;
		end else if (accept) begin
			if (pixel.last_pixel) begin
				pix_cnt_q <= '0;
				grn_cnt_q <= '0;
				hlt_cnt_q <= '0;
			end else begin
				pix_cnt_q <= pix_nxt;
				grn_cnt_q <= grn_nxt;
				hlt_cnt_q <= hlt_nxt;
			end
		end
	end

	assign snap_push    = accept && pixel.last_pixel;
	assign snap.pixels  = pix_nxt;
	assign snap.green   = grn_nxt;
	assign snap.healthy = hlt_nxt;

endmodule

@@ hdl/hgpc_snap_fifo.sv @@
// Two-entry queue of frame count snapshots between front and back.
module hgpc_snap_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hgpc_pkg::snap_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output hgpc_pkg::snap_t rdata
);

	hgpc_pkg::snap_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = mem_q[rd_ptr_q];

endmodule

@@ hdl/hgpc_back.sv @@
// Back end: shift-subtract divider for both percentages, grading, result register.
module hgpc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             snap_empty,
	input  hgpc_pkg::snap_t  snap,
	output logic             snap_pop,
	output logic             empty,
	input  logic             pop,
	output hgpc_pkg::result_t result
);

	localparam int unsigned DIVD_W = hgpc_pkg::DIVD_W;
	localparam int unsigned PCT_W  = hgpc_pkg::PCT_W;
	localparam int unsigned BIT_W  = hgpc_pkg::BIT_W;

	hgpc_pkg::back_state_t state_q, state_nxt;
	logic [DIVD_W-1:0] num_q, den_sh, mul_out;
	logic [hgpc_pkg::CNT_W-1:0] den_q, mul_src, den_src;
	logic [BIT_W-1:0] bit_q;
	logic [PCT_W-1:0] quot_q, quot_nxt, pct_fin, green_pct_q, healthy_pct_q;
	logic num_ge, last_bit;
	logic ld_green, ld_healthy, step, wr_res;
	logic res_valid_q;
	hgpc_pkg::result_t res_q;
	logic [1:0] grade;

	assign last_bit = (bit_q == '0);
	assign den_sh   = DIVD_W'(den_q) << bit_q;
	assign num_ge   = (num_q >= den_sh);
	assign quot_nxt = num_ge ? (quot_q | (PCT_W'(1) << bit_q)) : quot_q;

	// Empty denominator gives zero; clamp at a full hundred
	always_comb begin
		if (den_q == '0) begin
			pct_fin = '0;
		end else if (quot_nxt > hgpc_pkg::PCT_SCALE) begin
			pct_fin = hgpc_pkg::PCT_SCALE;
		end else begin
			pct_fin = quot_nxt;
		end
	end

	assign mul_src = ld_green ? snap.green : snap.healthy;
	assign den_src = ld_green ? snap.pixels : snap.green;
	assign mul_out = DIVD_W'(mul_src) * DIVD_W'(hgpc_pkg::PCT_SCALE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hgpc_pkg::BK_IDLE:        if (!snap_empty) state_nxt = hgpc_pkg::BK_DIV_GREEN;
			hgpc_pkg::BK_DIV_GREEN:   if (last_bit) state_nxt = hgpc_pkg::BK_DIV_HEALTHY;
			hgpc_pkg::BK_DIV_HEALTHY: if (last_bit) state_nxt = hgpc_pkg::BK_OUT;
			hgpc_pkg::BK_OUT:         if (!res_valid_q || pop) state_nxt = hgpc_pkg::BK_IDLE;
			default:                  state_nxt = hgpc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		ld_green   = 1'b0;
		ld_healthy = 1'b0;
		step       = 1'b0;
		wr_res     = 1'b0;
		case (state_q)
			hgpc_pkg::BK_IDLE:        ld_green = !snap_empty;
			hgpc_pkg::BK_DIV_GREEN: begin
				step       = 1'b1;
				ld_healthy = last_bit;
			end
			hgpc_pkg::BK_DIV_HEALTHY: step = 1'b1;
			hgpc_pkg::BK_OUT:         wr_res = !res_valid_q || pop;
			default: ;
		endcase
	end

	assign snap_pop = wr_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hgpc_pkg::BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (num_ge) begin
				num_q <= num_q - den_sh;
			end
			quot_q <= quot_nxt;
			bit_q  <= bit_q - 1'b1;
		end
		if (step && last_bit && state_q == hgpc_pkg::BK_DIV_GREEN) begin
			green_pct_q <= pct_fin;
		end
		if (step && last_bit && state_q == hgpc_pkg::BK_DIV_HEALTHY) begin
			healthy_pct_q <= pct_fin;
		end
		// Load the next division over the finished one
		if (ld_green || ld_healthy) begin
			num_q  <= mul_out;
			den_q  <= den_src;
			bit_q  <= BIT_W'(PCT_W - 1);
			quot_q <= '0;
		end
	end

	always_comb begin
		if (healthy_pct_q < hgpc_pkg::GRADE_CUT_LOW) begin
			grade = 2'd0;
		end else if (healthy_pct_q < hgpc_pkg::GRADE_CUT_MID) begin
			grade = 2'd1;
		end else if (healthy_pct_q < hgpc_pkg::GRADE_CUT_HIGH) begin
			grade = 2'd2;
		end else begin
			grade = 2'd3;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_res) begin
			res_q.frame_pixels    <= snap.pixels;
			res_q.green_pixels    <= snap.green;
			res_q.healthy_pixels  <= snap.healthy;
			res_q.green_percent   <= green_pct_q;
			res_q.healthy_percent <= healthy_pct_q;
			res_q.health_grade    <= grade;
			res_q.no_green        <= (snap.green == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (wr_res) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	assign empty  = !res_valid_q;
	assign result = res_q;

endmodule

@@ hdl/hsv_green_pixel_census_top.sv @@
// Top level of the HSV green pixel census: config, front, snapshot queue, back.
//
// channel   direction  handshake                      payload
// pixel     in         push / full                    hgpc_pkg::pixel_t
// result    out        empty / pop                    hgpc_pkg::result_t
// config    in         psel penable pwrite, pready=1  paddr, pwdata, prdata
//
// One pixel is taken every cycle while full is low; the front counters then take a pixel per clock.
// A frame summary passes through the back divider after its last pixel in steps:
// one load, seven quotient bits for each of the two percentages, one write.
// full rises only while the queue holds two frame summaries not yet written to the result.
// Reset clears counters, queue pointers and the result valid flag at once; no clearing pass.
module hsv_green_pixel_census_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  hgpc_pkg::pixel_t             pixel,
	output logic                         empty,
	input  logic                         pop,
	output hgpc_pkg::result_t            result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hgpc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	hgpc_pkg::cfg_t  cfg;
	hgpc_pkg::snap_t snap_in, snap_out;
	logic snap_push, snap_pop, snap_full, snap_empty;

	assign pready = 1'b1;

	hgpc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	hgpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.pixel     (pixel),
		.full      (full),
		.snap_full (snap_full),
		.snap_push (snap_push),
		.snap      (snap_in)
	);

	hgpc_snap_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (snap_push),
		.wdata  (snap_in),
		.full   (snap_full),
		.pop    (snap_pop),
		.empty  (snap_empty),
		.rdata  (snap_out)
	);

	hgpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_empty (snap_empty),
		.snap       (snap_out),
		.snap_pop   (snap_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	// A last-pixel transfer always leaves a summary waiting for the back end
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && pixel.last_pixel |=> !snap_empty)
		else $error("frame summary not queued after last pixel");

	// Counts stay nested: healthy within green within frame
	a_nested_counts: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.green_pixels <= result.frame_pixels) &&
			(result.healthy_pixels <= result.green_pixels))
		else $error("result counts out of order");

	// A frame without green reports zero healthy share and lowest grade
	a_no_green: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.no_green |-> (result.healthy_percent == '0) &&
			(result.health_grade == 2'd0))
		else $error("no-green result carries a healthy share");

	// The back end only takes a summary when it writes the result register
	a_pop_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		snap_pop |=> !empty)
		else $error("summary dropped without a result");

endmodule

@@ verif/tb_top.sv @@
// Testbench for the HSV green pixel census: frame summaries checked against a local census model.
module tb_top;

	localparam int unsigned CH_W      = hgpc_pkg::CH_W;
	localparam int unsigned CNT_W     = hgpc_pkg::CNT_W;
	localparam int unsigned PCT_W     = hgpc_pkg::PCT_W;
	localparam int unsigned REG_IDX_W = hgpc_pkg::REG_IDX_W;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned RUN_LIMIT    = 400000;
	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned ITEMS_PER_MODE = 400;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              push    = 1'b0;
	hgpc_pkg::pixel_t  pixel   = '0;
	logic              pop     = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [hgpc_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata  = '0;
	logic              full;
	logic              empty;
	hgpc_pkg::result_t result;
	logic [31:0]       prdata;
	logic              pready;

	// census model: thresholds, running frame counts and summaries still owed
	hgpc_pkg::cfg_t    census_cfg;
	logic [CNT_W-1:0]  pix_cnt;
	logic [CNT_W-1:0]  grn_cnt;
	logic [CNT_W-1:0]  hlth_cnt;
	hgpc_pkg::result_t summary_q[$];

	int unsigned errors        = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_pct = 26;
	int unsigned recv_idle_pct = 77;

	hsv_green_pixel_census_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic hgpc_pkg::cfg_t reset_census_cfg();
		hgpc_pkg::cfg_t c;
		c.green_hue_low    = hgpc_pkg::RST_GREEN_HUE_LOW;
		c.green_hue_high   = hgpc_pkg::RST_GREEN_HUE_HIGH;
		c.green_sat_low    = hgpc_pkg::RST_GREEN_SAT_LOW;
		c.green_val_low    = hgpc_pkg::RST_GREEN_VAL_LOW;
		c.green_val_high   = hgpc_pkg::RST_GREEN_VAL_HIGH;
		c.healthy_hue_low  = hgpc_pkg::RST_HEALTHY_HUE_LOW;
		c.healthy_hue_high = hgpc_pkg::RST_HEALTHY_HUE_HIGH;
		return c;
	endfunction

	function automatic logic [CH_W-1:0] cfg_field(hgpc_pkg::cfg_t c,
			logic [REG_IDX_W-1:0] idx);
		case (idx)
			hgpc_pkg::REG_GREEN_HUE_LOW:    return c.green_hue_low;
			hgpc_pkg::REG_GREEN_HUE_HIGH:   return c.green_hue_high;
			hgpc_pkg::REG_GREEN_SAT_LOW:    return c.green_sat_low;
			hgpc_pkg::REG_GREEN_VAL_LOW:    return c.green_val_low;
			hgpc_pkg::REG_GREEN_VAL_HIGH:   return c.green_val_high;
			hgpc_pkg::REG_HEALTHY_HUE_LOW:  return c.healthy_hue_low;
			hgpc_pkg::REG_HEALTHY_HUE_HIGH: return c.healthy_hue_high;
			default:                        return '0;
		endcase
	endfunction

	function automatic hgpc_pkg::cfg_t cfg_with(hgpc_pkg::cfg_t c,
			logic [REG_IDX_W-1:0] idx, logic [CH_W-1:0] v);
		case (idx)
			hgpc_pkg::REG_GREEN_HUE_LOW:    c.green_hue_low    = v;
			hgpc_pkg::REG_GREEN_HUE_HIGH:   c.green_hue_high   = v;
			hgpc_pkg::REG_GREEN_SAT_LOW:    c.green_sat_low    = v;
			hgpc_pkg::REG_GREEN_VAL_LOW:    c.green_val_low    = v;
			hgpc_pkg::REG_GREEN_VAL_HIGH:   c.green_val_high   = v;
			hgpc_pkg::REG_HEALTHY_HUE_LOW:  c.healthy_hue_low  = v;
			hgpc_pkg::REG_HEALTHY_HUE_HIGH: c.healthy_hue_high = v;
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [PCT_W-1:0] percent_floor(logic [CNT_W-1:0] num,
			logic [CNT_W-1:0] den);
		longint unsigned q;
		if (den == 0)
			return '0;
		q = (longint'(num) * 100) / longint'(den);
		if (q > 100)
			q = 100;
		return PCT_W'(q);
	endfunction

	// classify one accepted pixel and close the frame on its last pixel
	task automatic census_accept(input hgpc_pkg::pixel_t px);
		logic              is_green;
		logic              is_healthy;
		hgpc_pkg::result_t r;
		is_green = px.saturation > census_cfg.green_sat_low &&
			px.brightness > census_cfg.green_val_low &&
			px.brightness < census_cfg.green_val_high &&
			px.hue > census_cfg.green_hue_low && px.hue < census_cfg.green_hue_high;
		is_healthy = is_green && px.hue > census_cfg.healthy_hue_low &&
			px.hue < census_cfg.healthy_hue_high;
		if (pix_cnt < hgpc_pkg::CNT_MAX)
			pix_cnt++;
		if (is_green && grn_cnt < hgpc_pkg::CNT_MAX)
			grn_cnt++;
		if (is_healthy && hlth_cnt < hgpc_pkg::CNT_MAX)
			hlth_cnt++;
		if (px.last_pixel) begin
			r.frame_pixels    = pix_cnt;
			r.green_pixels    = grn_cnt;
			r.healthy_pixels  = hlth_cnt;
			r.green_percent   = percent_floor(grn_cnt, pix_cnt);
			r.healthy_percent = percent_floor(hlth_cnt, grn_cnt);
			if (r.healthy_percent < hgpc_pkg::GRADE_CUT_LOW)
				r.health_grade = 2'd0;
			else if (r.healthy_percent < hgpc_pkg::GRADE_CUT_MID)
				r.health_grade = 2'd1;
			else if (r.healthy_percent < hgpc_pkg::GRADE_CUT_HIGH)
				r.health_grade = 2'd2;
			else
				r.health_grade = 2'd3;
			r.no_green = (grn_cnt == 0);
			summary_q.push_back(r);
			pix_cnt  = '0;
			grn_cnt  = '0;
			hlth_cnt = '0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		hgpc_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (summary_q.size() == 0) begin
				$display("%0t: summary expected none got %p", $time, result);
				errors++;
			end else begin
				want = summary_q.pop_front();
				check_field("frame_pixels", 32'(want.frame_pixels),
					32'(result.frame_pixels));
				check_field("green_pixels", 32'(want.green_pixels),
					32'(result.green_pixels));
				check_field("healthy_pixels", 32'(want.healthy_pixels),
					32'(result.healthy_pixels));
				check_field("green_percent", 32'(want.green_percent),
					32'(result.green_percent));
				check_field("healthy_percent", 32'(want.healthy_percent),
					32'(result.healthy_percent));
				check_field("health_grade", 32'(want.health_grade),
					32'(result.health_grade));
				check_field("no_green", 32'(want.no_green), 32'(result.no_green));
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// push stays high across back-to-back transfers; it drops only for a gap
	task automatic send_pixel(input hgpc_pkg::pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (full)
			@(posedge clk);
		census_accept(px);
	endtask

	// hold off until every summary has arrived and the divider has emptied
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (summary_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		census_cfg = cfg_with(census_cfg, idx, data[CH_W-1:0]);
		@(posedge clk);
	endtask

	task automatic reg_read_check(input logic [REG_IDX_W-1:0] idx);
		logic [31:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = {24'd0, cfg_field(census_cfg, idx)};
		if (prdata !== want) begin
			$display("%0t: register %0d expected %0d got %0d", $time, idx, want, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write every threshold (junk in the upper bits) and read each one back
	task automatic program_census(input hgpc_pkg::cfg_t c);
		for (int i = int'(hgpc_pkg::REG_GREEN_HUE_LOW);
				i <= int'(hgpc_pkg::REG_HEALTHY_HUE_HIGH); i++)
			reg_write(REG_IDX_W'(i), ($urandom() & 32'hFFFF_FF00) |
				32'(cfg_field(c, REG_IDX_W'(i))));
		for (int i = int'(hgpc_pkg::REG_GREEN_HUE_LOW);
				i <= int'(hgpc_pkg::REG_HEALTHY_HUE_HIGH); i++)
			reg_read_check(REG_IDX_W'(i));
	endtask

	function automatic int strictly_between(int lo, int hi);
		if (hi > lo + 1)
			return lo + 1 + int'($urandom_range(hi - lo - 2));
		return int'($urandom_range(255));
	endfunction

	function automatic logic [CH_W-1:0] near(logic [CH_W-1:0] thr);
		return CH_W'(int'(thr) + int'($urandom_range(2)) - 1);
	endfunction

	function automatic hgpc_pkg::pixel_t make_pixel(int green_bias, int healthy_bias,
			bit last);
		hgpc_pkg::pixel_t px;
		int     lo;
		int     hi;
		if ($urandom_range(99) < green_bias) begin
			lo = int'(census_cfg.green_hue_low);
			hi = int'(census_cfg.green_hue_high);
			if ($urandom_range(99) < healthy_bias) begin
				if (int'(census_cfg.healthy_hue_low) > lo)
					lo = int'(census_cfg.healthy_hue_low);
				if (int'(census_cfg.healthy_hue_high) < hi)
					hi = int'(census_cfg.healthy_hue_high);
			end
			px.hue        = CH_W'(strictly_between(lo, hi));
			px.saturation = CH_W'(strictly_between(int'(census_cfg.green_sat_low), 256));
			px.brightness = CH_W'(strictly_between(int'(census_cfg.green_val_low),
				int'(census_cfg.green_val_high)));
		end else begin
			case ($urandom_range(5))
				0:       px.hue = near(census_cfg.green_hue_low);
				1:       px.hue = near(census_cfg.green_hue_high);
				2:       px.hue = near(census_cfg.healthy_hue_low);
				3:       px.hue = near(census_cfg.healthy_hue_high);
				4:       px.hue = CH_W'($urandom_range(179));
				default: px.hue = CH_W'($urandom_range(255));
			endcase
			case ($urandom_range(2))
				0:       px.saturation = near(census_cfg.green_sat_low);
				1:       px.saturation = $urandom_range(1) ? 8'd255 : 8'd0;
				default: px.saturation = CH_W'($urandom_range(255));
			endcase
			case ($urandom_range(2))
				0:       px.brightness = near(census_cfg.green_val_low);
				1:       px.brightness = near(census_cfg.green_val_high);
				default: px.brightness = CH_W'($urandom_range(255));
			endcase
		end
		px.last_pixel = last;
		return px;
	endfunction

	function automatic hgpc_pkg::pixel_t hsv(int h, int s, int v, bit last);
		return '{hue: CH_W'(h), saturation: CH_W'(s), brightness: CH_W'(v),
			last_pixel: last};
	endfunction

	task automatic send_frame(input int len, input int green_bias, input int healthy_bias);
		for (int i = 0; i < len; i++)
			send_pixel(make_pixel(green_bias, healthy_bias, i == len - 1));
	endtask

	function automatic int frame_length();
		int pick;
		pick = int'($urandom_range(99));
		if (pick < 80)
			return int'($urandom_range(16, 1));
		if (pick < 95)
			return int'($urandom_range(64, 17));
		return int'($urandom_range(150, 100));
	endfunction

	function automatic hgpc_pkg::cfg_t random_census_cfg();
		hgpc_pkg::cfg_t c;
		if ($urandom_range(4) == 0) begin
			c = hgpc_pkg::cfg_t'({$urandom(), 24'($urandom())});
		end else begin
			c.green_hue_low    = CH_W'($urandom_range(120));
			c.green_hue_high   = CH_W'(32'(c.green_hue_low) + $urandom_range(59));
			c.healthy_hue_low  = CH_W'($urandom_range(c.green_hue_high, c.green_hue_low));
			c.healthy_hue_high = CH_W'(32'(c.healthy_hue_low) + $urandom_range(40));
			c.green_sat_low    = CH_W'($urandom_range(200));
			c.green_val_low    = CH_W'($urandom_range(120));
			c.green_val_high   = CH_W'(32'(c.green_val_low) + $urandom_range(135));
		end
		return c;
	endfunction

	// band edges, channel extremes, lone-pixel frames and grade boundaries
	task automatic test_directed();
		send_pixel(hsv(60, 255, 100, 1));
		send_pixel(hsv(0, 0, 0, 1));
		send_pixel(hsv(255, 255, 255, 1));
		send_pixel(hsv(45, 100, 100, 0));
		send_pixel(hsv(46, 100, 100, 0));
		send_pixel(hsv(79, 100, 100, 0));
		send_pixel(hsv(80, 100, 100, 0));
		send_pixel(hsv(55, 100, 100, 0));
		send_pixel(hsv(56, 100, 100, 0));
		send_pixel(hsv(64, 100, 100, 0));
		send_pixel(hsv(65, 100, 100, 0));
		send_pixel(hsv(60, 30, 100, 0));
		send_pixel(hsv(60, 31, 31, 0));
		send_pixel(hsv(60, 100, 30, 0));
		send_pixel(hsv(60, 100, 199, 0));
		send_pixel(hsv(60, 100, 200, 0));
		send_pixel(hsv(179, 255, 128, 1));
		// one healthy in five green: exactly on the lowest grade cut
		send_pixel(hsv(60, 100, 100, 0));
		for (int i = 0; i < 4; i++)
			send_pixel(hsv(70, 100, 100, i == 3));
		settle();
	endtask

	task automatic test_register_access();
		hgpc_pkg::cfg_t c;
		for (int i = int'(hgpc_pkg::REG_GREEN_HUE_LOW);
				i <= int'(hgpc_pkg::REG_HEALTHY_HUE_HIGH); i++)
			reg_read_check(REG_IDX_W'(i));
		c = random_census_cfg();
		program_census(c);
		// a write to the unused slot must leave every threshold alone
		reg_write(REG_UNUSED, $urandom());
		for (int i = int'(hgpc_pkg::REG_GREEN_HUE_LOW);
				i <= int'(hgpc_pkg::REG_HEALTHY_HUE_HIGH); i++)
			reg_read_check(REG_IDX_W'(i));
		for (int f = 0; f < 4; f++)
			send_frame(frame_length(), int'($urandom_range(100)),
				int'($urandom_range(100)));
		settle();
	endtask

	task automatic test_config_extremes();
		hgpc_pkg::cfg_t c;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: c = '0;
				1: c = '1;
				2: c = '{green_hue_low: 8'd0, green_hue_high: 8'd255, green_sat_low: 8'd0,
					green_val_low: 8'd0, green_val_high: 8'd255, healthy_hue_low: 8'd0,
					healthy_hue_high: 8'd255};
				default: begin
					c = reset_census_cfg();
					c.healthy_hue_low  = c.green_hue_low;
					c.healthy_hue_high = c.green_hue_high;
				end
			endcase
			program_census(c);
			for (int f = 0; f < 6; f++)
				send_frame(int'($urandom_range(12, 1)), int'($urandom_range(100)),
					int'($urandom_range(100)));
			settle();
		end
		program_census(reset_census_cfg());
	endtask

	task automatic test_random_traffic(input int unsigned items);
		int unsigned sent;
		int unsigned epoch;
		int          len;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(3) == 0)
				program_census(reset_census_cfg());
			else
				program_census(random_census_cfg());
			epoch = 0;
			while (epoch < 150) begin
				len = frame_length();
				send_frame(len, int'($urandom_range(100)), int'($urandom_range(100)));
				epoch += len;
			end
			sent += epoch;
			settle();
		end
	endtask

	initial begin
		census_cfg = reset_census_cfg();
		pix_cnt    = '0;
		grn_cnt    = '0;
		hlth_cnt   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 77;
		test_directed();
		test_register_access();
		test_config_extremes();
		test_random_traffic(ITEMS_PER_MODE);

		send_idle_pct = 77;
		recv_idle_pct = 26;
		test_random_traffic(ITEMS_PER_MODE);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(ITEMS_PER_MODE);

		settle();
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

@@ hsv_green_pixel_census_top.f @@
hdl/hgpc_pkg.sv
hdl/hgpc_cfg.sv
hdl/hgpc_front.sv
hdl/hgpc_snap_fifo.sv
hdl/hgpc_back.sv
hdl/hsv_green_pixel_census_top.sv
verif/tb_top.sv
